@@ design/lar_pkg.sv @@
// Shared types, constants and cell rule for the Life row stepper.
package lar_pkg;

  localparam int ROW_WIDTH     = 64;
  localparam int WIDTH_BITS    = 7;
  localparam int COUNT_BITS    = 4;
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int LVL_BITS      = $clog2(FIFO_DEPTH + 1);

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(ROW_WIDTH);

  typedef logic [ROW_WIDTH-1:0] row_t;

  typedef struct packed {
    row_t cells;
    logic last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  beat0;
    out_beat_t  beat1;
  } push_t;

  // Cells at or above the active width are dead.
  function automatic row_t width_mask(input logic [WIDTH_BITS-1:0] w);
    logic [ROW_WIDTH:0] t;
    t = ({{ROW_WIDTH{1'b0}}, 1'b1} << w) - 1'b1;
    if (w >= WIDTH_BITS'(ROW_WIDTH)) begin
      return '1;
    end
    return t[ROW_WIDTH-1:0];
  endfunction

  // B3/S23 rule on a 3x3 neighborhood; the center is mid[1].
  function automatic logic life_cell(input logic [2:0] up, input logic [2:0] mid,
                                     input logic [2:0] dn);
    logic [COUNT_BITS-1:0] n;
    n = COUNT_BITS'(up[0]) + COUNT_BITS'(up[1]) + COUNT_BITS'(up[2]) +
        COUNT_BITS'(mid[0]) + COUNT_BITS'(mid[2]) +
        COUNT_BITS'(dn[0]) + COUNT_BITS'(dn[1]) + COUNT_BITS'(dn[2]);
    return (n == COUNT_BITS'(BIRTH_COUNT)) ||
           (mid[1] && (n == COUNT_BITS'(SURVIVE_COUNT)));
  endfunction

endpackage

@@ design/life_automaton_row_step.sv @@
// Conway Life (B3/S23) row stepper with dead borders. It takes one row beat per
// clock and sends each next-generation row once the row below it has arrived, so
// output runs one row behind input; the beat flagged tlast releases the last one
// or two rows of the frame. A beat is held in the input register, the
// neighbor counts and rule for a whole row are combinational, and results wait
// in a four-beat queue; a new row beat is taken every cycle while the queue has
// room for two results, so a stalled output stops input after a few beats.
module life_automaton_row_step
  import lar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_BITS-1:0] cfg_wr_data,  // active_width
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ROW_WIDTH-1:0]  in_tdata,     // row_cells
  input  logic                  in_tlast,     // last_row
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ROW_WIDTH-1:0]  out_tdata,    // next_row_cells
  output logic                  out_tlast     // last_of_frame
);

  logic [WIDTH_BITS-1:0] width_r;
  logic                  in_valid_r;
  row_t                  in_row_r;
  logic                  in_last_r;
  row_t                  upper_r, upper_nxt;
  row_t                  middle_r, middle_nxt;
  logic                  mid_valid_r, mid_valid_nxt;
  row_t                  mask;
  row_t                  row_mid, row_new, above_new;
  logic                  room_ok, advance;
  push_t                 push;
  out_beat_t             out_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      width_r <= cfg_wr_data;
    end
  end

  assign mask      = width_mask(width_r);
  assign advance   = in_valid_r && room_ok;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_row_r  <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Held middle row, finished now that the row below it is here.
  lar_row_calc u_calc_mid (
    .mask     (mask),
    .above    (upper_r),
    .here     (middle_r),
    .below    (in_row_r),
    .next_row (row_mid)
  );

  // Newest row closed off by the bottom border; its result is used only on the last beat.
  assign above_new = mid_valid_r ? middle_r : '0;

  lar_row_calc u_calc_new (
    .mask     (mask),
    .above    (above_new),
    .here     (in_row_r),
    .below    ('0),
    .next_row (row_new)
  );

  always_comb begin
    push.cnt         = 2'd0;
    push.beat0.cells = row_mid;
    push.beat0.last  = 1'b0;
    push.beat1.cells = row_new;
    push.beat1.last  = 1'b1;
    if (advance) begin
      if (mid_valid_r) begin
        push.cnt = in_last_r ? 2'd2 : 2'd1;
      end else if (in_last_r) begin
        push.cnt        = 2'd1;
        push.beat0      = push.beat1;
      end
    end
  end

  // A row is stored already cut to the width in force when it advances, so a
  // later wider setting cannot bring its upper cells back to life.
  always_comb begin
    upper_nxt     = upper_r;
    middle_nxt    = middle_r;
    mid_valid_nxt = mid_valid_r;
    if (advance) begin
      if (in_last_r) begin
        upper_nxt     = '0;
        middle_nxt    = '0;
        mid_valid_nxt = 1'b0;
      end else begin
        upper_nxt     = above_new;
        middle_nxt    = in_row_r & mask;
        mid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r     <= '0;
      middle_r    <= '0;
      mid_valid_r <= 1'b0;
    end else begin
      upper_r     <= upper_nxt;
      middle_r    <= middle_nxt;
      mid_valid_r <= mid_valid_nxt;
    end
  end

  lar_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room_ok    (room_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_beat   (out_beat)
  );

  assign out_tdata = out_beat.cells;
  assign out_tlast = out_beat.last;

endmodule

@@ design/lar_row_calc.sv @@
// Next-generation computation of one row from the rows above, at and below it.
module lar_row_calc
  import lar_pkg::*;
(
  input  row_t mask,
  input  row_t above,
  input  row_t here,
  input  row_t below,
  output row_t next_row
);

  logic [ROW_WIDTH+1:0] a_pad, h_pad, b_pad;
  row_t res;

  // A zero on each side gives the dead left and right borders.
  assign a_pad = {1'b0, above & mask, 1'b0};
  assign h_pad = {1'b0, here & mask, 1'b0};
  assign b_pad = {1'b0, below & mask, 1'b0};

  always_comb begin
    for (int i = 0; i < ROW_WIDTH; i++) begin
      res[i] = life_cell(a_pad[i +: 3], h_pad[i +: 3], b_pad[i +: 3]);
    end
  end

  assign next_row = res & mask;

endmodule

@@ design/lar_out_fifo.sv @@
// Small result queue that takes up to two beats per cycle and sends one while the receiver is ready.
module lar_out_fifo
  import lar_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room_ok,
  output logic      out_tvalid,
  input  logic      out_tready,
  output out_beat_t out_beat
);

  out_beat_t              mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [LVL_BITS-1:0]    level_r, level_nxt;
  logic                   pop;
  logic [PTR_BITS-1:0]    wptr_p1;

  assign out_tvalid = (level_r != '0);
  assign out_beat   = mem_r[rptr_r];
  assign pop        = out_tvalid && out_tready;
  // Room for the worst case of two beats from one item.
  assign room_ok    = (level_r <= LVL_BITS'(FIFO_DEPTH - 2));
  assign wptr_p1    = wptr_r + 1'b1;

  always_comb begin
    wptr_nxt  = wptr_r + PTR_BITS'(push.cnt);
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    level_nxt = level_r + LVL_BITS'(push.cnt) - LVL_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      level_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wptr_r] <= push.beat0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wptr_p1] <= push.beat1;
    end
  end

endmodule

@@ tb/life_row_checker.sv @@
// Checker for the Life row stepper: predicts each next-generation row and compares output beats.
module life_row_checker
  import lar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_BITS-1:0] cfg_wr_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [ROW_WIDTH-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [ROW_WIDTH-1:0]  out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    outstanding,
  output int                    results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  logic [WIDTH_BITS-1:0] width_q = WIDTH_RESET;
  row_t                  upper_q = '0;
  row_t                  middle_q = '0;
  logic                  middle_held = 1'b0;
  out_beat_t             pending_rows[$];
  int                    errs = 0;
  int                    checked = 0;

  function automatic row_t active_mask(input logic [WIDTH_BITS-1:0] w);
    row_t m;
    if (w >= ROW_WIDTH) begin
      m = '1;
    end else begin
      m = (row_t'(1) << w) - row_t'(1);
    end
    return m;
  endfunction

  function automatic row_t next_generation_row(input row_t above, input row_t here,
                                               input row_t below, input row_t m);
    row_t a;
    row_t h;
    row_t b;
    row_t res;
    int   n;
    a = above & m;
    h = here & m;
    b = below & m;
    res = '0;
    for (int i = 0; i < ROW_WIDTH; i++) begin
      n = int'(a[i]) + int'(b[i]);
      if (i > 0) begin
        n += int'(a[i-1]) + int'(h[i-1]) + int'(b[i-1]);
      end
      if (i < ROW_WIDTH - 1) begin
        n += int'(a[i+1]) + int'(h[i+1]) + int'(b[i+1]);
      end
      res[i] = (n == BIRTH_COUNT) || (h[i] && n == SURVIVE_COUNT);
    end
    return res & m;
  endfunction

  always @(posedge clk) begin
    row_t      m;
    row_t      row;
    out_beat_t want;
    out_beat_t got;
    if (!rst_n) begin
      width_q = WIDTH_RESET;
      upper_q = '0;
      middle_q = '0;
      middle_held = 1'b0;
      pending_rows.delete();
    end else begin
      if (cfg_wr_en) begin
        width_q = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        m = active_mask(width_q);
        row = in_tdata & m;
        // The held row gets its result once the row below it is known.
        if (middle_held) begin
          want.cells = next_generation_row(upper_q, middle_q, row, m);
          want.last = 1'b0;
          pending_rows = {pending_rows, want};
          upper_q = middle_q;
        end else begin
          upper_q = '0;
        end
        middle_q = row;
        middle_held = 1'b1;
        if (in_tlast) begin
          want.cells = next_generation_row(upper_q, middle_q, '0, m);
          want.last = 1'b1;
          pending_rows = {pending_rows, want};
          upper_q = '0;
          middle_q = '0;
          middle_held = 1'b0;
        end
      end
      if (out_tvalid && out_tready) begin
        got.cells = out_tdata;
        got.last = out_tlast;
        if (pending_rows.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS) begin
            $display("unexpected output beat: next_row_cells %h last_of_frame %b",
                     got.cells, got.last);
          end
        end else begin
          want = pending_rows.pop_front();
          checked++;
          if (got.cells !== want.cells || got.last !== want.last) begin
            errs++;
            if (errs <= MAX_REPORTS) begin
              $display("mismatch on result %0d: next_row_cells exp %h got %h", checked,
                       want.cells, got.cells);
              $display("  last_of_frame exp %b got %b", want.last, got.last);
            end
          end
        end
      end
    end
    fail_count <= errs;
    outstanding <= pending_rows.size();
    results_checked <= checked;
  end

endmodule

@@ tb/testbench.sv @@
// Top of the Life row stepper testbench: clock, reset, stimulus, output stalls and verdict.
module testbench;
  import lar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 10;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [WIDTH_BITS-1:0] cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  row_t                  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  row_t                  out_tdata;
  logic                  out_tlast;

  int       fail_count;
  int       outstanding;
  int       results_checked;

  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_reqs = 0;
  int       holds_done = 0;
  int       hold_left = 0;
  int       rx_cyc = 0;
  int       idle_cycles = 0;

  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  int       rows_left = 0;
  int       items_sent = 0;
  int       frames_sent = 0;
  int       widths_written = 0;

  always #1 clk = ~clk;

  life_automaton_row_step dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // row_cells
    .in_tlast    (in_tlast),     // last_row
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // next_row_cells
    .out_tlast   (out_tlast)     // last_of_frame
  );

  life_row_checker row_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Receiver: a long hold-off when one is requested, otherwise the current stall pattern.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      holds_done <= holds_done + 1;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_tready <= 1'b1;
        RX_COIN:    out_tready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: out_tready <= ((rx_cyc % 7) < 4);
        default:    out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[life_automaton_row_step] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic row_t rand_row();
    row_t r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = r & {$urandom, $urandom};
      1: r = r | {$urandom, $urandom};
      2: r = '0;
      3: r = '1;
      default: ;
    endcase
    return r;
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the beat.
  task automatic send_row(input row_t cells, input logic last);
    int gap;
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= cells;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (last) begin
      frames_sent++;
    end
  endtask

  task automatic send_random_row();
    if (rows_left == 0) begin
      rows_left = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
    end
    rows_left--;
    send_row(rand_row(), rows_left == 0);
  endtask

  // A held row yields no result yet, so allow the pipeline to settle before a write.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_BITS-1:0] w);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    widths_written++;
  endtask

  initial begin
    logic [WIDTH_BITS-1:0] w;
    rx_mode_t              mode;
    int                    n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_width(7'd64);
    send_row('1, 1'b1);
    send_row('1, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('0, 1'b1);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // Narrow the width while two rows of a frame are still held.
    send_row('1, 1'b0);
    send_row(64'hF0F0_F0F0_F0F0_F0F0, 1'b0);
    wait_quiet();
    write_width(7'd5);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    wait_quiet();
    write_width(7'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    wait_quiet();
    write_width(7'd1);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    wait_quiet();
    write_width(7'd127);
    send_row(rand_row(), 1'b0);
    send_row(rand_row(), 1'b1);
    wait_quiet();
    write_width(7'd65);
    send_row('1, 1'b1);
    wait_quiet();
    write_width(7'd3);
    send_row(64'h2, 1'b0);
    send_row(64'h2, 1'b0);
    send_row(64'h2, 1'b1);

    // Random phases; a phase may end inside a frame, so widths also change mid-frame.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_quiet();
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = WIDTH_BITS'($urandom_range(65, 127));
        2:       w = 7'd1;
        3:       w = WIDTH_BITS'($urandom_range(2, 8));
        4, 5:    w = 7'd64;
        default: w = WIDTH_BITS'($urandom_range(1, 64));
      endcase
      write_width(w);
      if (p == 1 || p == 6) begin
        // The sender keeps offering while the output is held, so the block backs up.
        gaps_on = 1'b0;
        mode = RX_ALWAYS;
        hold_reqs <= hold_reqs + 1;
      end else if (p % 3 == 2) begin
        gaps_on = 1'b0;
        mode = RX_ALWAYS;
      end else begin
        gaps_on = 1'b1;
        mode = rx_mode_t'($urandom_range(0, 3));
      end
      rx_mode <= mode;
      n = $urandom_range(45, 65);
      repeat (n) send_random_row();
    end
    while (rows_left != 0) send_random_row();
    wait_quiet();

    $display("Sent %0d row beats in %0d frames over %0d width settings,", items_sent,
             frames_sent, widths_written);
    $display("with bursty input, output stalls and %0d long hold-offs; %0d rows checked.",
             holds_done, results_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[life_automaton_row_step] OK");
    end else begin
      $display("[life_automaton_row_step] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/lar_pkg.sv
design/lar_row_calc.sv
design/lar_out_fifo.sv
design/life_automaton_row_step.sv
tb/life_row_checker.sv
tb/testbench.sv
